// ===== rtl/whp_pkg.sv =====
// types and constants shared by the wav header parser modules
// depends on nothing
package whp_pkg;

	localparam int unsigned DIVISOR_W = 18;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [31:0] TAG_RIFF      = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE      = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT       = 32'h666D_7420;
	localparam logic [31:0] TAG_LIST      = 32'h4C49_5354;
	localparam logic [31:0] TAG_CUE       = 32'h6375_6520;
	localparam logic [31:0] TAG_FACT      = 32'h6661_6374;
	localparam logic [31:0] TAG_DATA      = 32'h6461_7461;
	localparam logic [31:0] FMT_PCM       = 32'h0000_0001;
	localparam logic [31:0] FMT_BASE_SIZE = 32'h0000_0010;
	localparam logic [31:0] MAX_BITS      = 32'd24;

	typedef enum logic [4:0] {
		PH_RIFF,
		PH_RSIZE,
		PH_WAVE,
		PH_TAG,
		PH_FSIZE,
		PH_FCAT,
		PH_FCHAN,
		PH_FRATE,
		PH_FBRATE,
		PH_FALIGN,
		PH_FBITS,
		PH_FSKIP,
		PH_CSIZE,
		PH_CSKIP,
		PH_DSIZE,
		PH_PAYLOAD,
		PH_DONE,
		PH_ERROR,
		PH_DIV
	} phase_t;

	typedef enum logic [1:0] {
		EV_HDR,
		EV_PAY,
		EV_ERR,
		EV_IGN
	} ev_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_RIFF,
		ERR_WAVE,
		ERR_PCM,
		ERR_BITS,
		ERR_CHUNK,
		ERR_NOFMT
	} err_t;

	typedef enum logic [1:0] {
		REM_HOLD,
		REM_FMT,
		REM_LOAD,
		REM_DEC
	} rem_op_t;

	typedef struct packed {
		logic    restart;
		logic    collect;
		logic    big;
		logic    two_byte;
		rem_op_t rem_op;
		logic    set_chan;
		logic    set_rate;
		logic    set_bits;
		logic    div_start;
		logic    set_samples;
		logic    set_err;
		err_t    err;
		logic    out_load;
		ev_t     ev;
		logic    last;
		logic    fmt_valid;
	} whp_cmd_t;

	typedef struct packed {
		logic first;
		logic fld_done;
		logic tag_riff;
		logic tag_wave;
		logic tag_fmt;
		logic tag_skip;
		logic tag_data;
		logic fmt_pcm;
		logic bits_ok;
		logic val_zero;
		logic chan_zero;
		logic bits_zero;
		logic rem_zero;
		logic rem_one;
		logic div_done;
		logic out_busy;
	} whp_status_t;

endpackage

// ===== rtl/whp_if.sv =====
// valid/ready channel interfaces for the file byte stream and the results
// depends on nothing
interface whp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       first_byte;

	modport source (output valid, output in_byte, output first_byte, input ready);
	modport sink (input valid, input in_byte, input first_byte, output ready);
endinterface

interface whp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [7:0]  payload;
	logic        last_payload;
	logic        format_valid;
	logic [15:0] channel_count;
	logic [31:0] rate_hz;
	logic [4:0]  sample_bits;
	logic [31:0] sample_count;
	logic [2:0]  error_code;

	modport source (output valid, output event_res, output payload, output last_payload,
		output format_valid, output channel_count, output rate_hz, output sample_bits,
		output sample_count, output error_code, input ready);
	modport sink (input valid, input event_res, input payload, input last_payload,
		input format_valid, input channel_count, input rate_hz, input sample_bits,
		input sample_count, input error_code, output ready);
endinterface

// ===== rtl/whp_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on whp_pkg
module whp_div import whp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [31:0]          quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/whp_datapath.sv =====
// field assembly, held format values, byte counter and result register
// depends on whp_pkg, whp_if and whp_div
module whp_datapath import whp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  in_byte,
	input  logic        first_byte,
	input  whp_cmd_t    cmd,
	output whp_status_t status,
	whp_res_if.source   result
);

	logic [1:0]           idx_q;
	logic [1:0]           idx_eff;
	logic [31:0]          asm_q;
	logic [31:0]          asm_base;
	logic [31:0]          asm_new;
	logic                 fld_done;
	logic [31:0]          rem_q;
	logic [15:0]          chan_q;
	logic [31:0]          rate_q;
	logic [4:0]           bits_q;
	logic [31:0]          samples_q;
	err_t                 err_q;
	logic [5:0]           bits_sum;
	logic [DIVISOR_W-1:0] divisor;
	logic                 div_done;
	logic [31:0]          quotient;
	logic                 valid_q;
	ev_t                  ev_q;
	logic [7:0]           pay_q;
	logic                 last_q;
	logic                 fv_q;

	assign idx_eff  = cmd.restart ? 2'd0 : idx_q;
	assign asm_base = (idx_eff == 2'd0) ? 32'd0 : asm_q;
	assign asm_new  = cmd.big ? {asm_base[23:0], in_byte}
		: (asm_base | ({24'd0, in_byte} << {idx_eff, 3'b000}));
	assign fld_done = cmd.two_byte ? (idx_eff != 2'd0) : (idx_eff == 2'd3);

	// bytes per sample times channels
	assign bits_sum = {1'b0, bits_q} + 6'd7;
	assign divisor  = DIVISOR_W'(chan_q) * DIVISOR_W'(bits_sum[5:3]);

	whp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (asm_new),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			asm_q     <= '0;
			rem_q     <= '0;
			chan_q    <= '0;
			rate_q    <= '0;
			bits_q    <= '0;
			samples_q <= '0;
			err_q     <= ERR_NONE;
		end else begin
			if (cmd.collect) begin
				asm_q <= asm_new;
				idx_q <= fld_done ? 2'd0 : idx_eff + 2'd1;
			end
			if (cmd.restart) begin
				rem_q <= '0;
			end else begin
				unique case (cmd.rem_op)
					REM_HOLD: ;
					REM_FMT:  rem_q <= (asm_new > FMT_BASE_SIZE) ? asm_new - FMT_BASE_SIZE : 32'd0;
					REM_LOAD: rem_q <= asm_new;
					REM_DEC:  rem_q <= rem_q - 32'd1;
					default:  ;
				endcase
			end
			if (cmd.set_chan) begin
				chan_q <= asm_new[15:0];
			end else if (cmd.restart) begin
				chan_q <= '0;
			end
			if (cmd.set_rate) begin
				rate_q <= asm_new;
			end else if (cmd.restart) begin
				rate_q <= '0;
			end
			if (cmd.set_bits) begin
				bits_q <= asm_new[4:0];
			end else if (cmd.restart) begin
				bits_q <= '0;
			end
			if (cmd.set_samples) begin
				samples_q <= quotient;
			end else if (cmd.restart) begin
				samples_q <= '0;
			end
			if (cmd.set_err) begin
				err_q <= cmd.err;
			end else if (cmd.restart) begin
				err_q <= ERR_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ev_q   <= cmd.ev;
			pay_q  <= (cmd.ev == EV_PAY) ? in_byte : 8'd0;
			last_q <= cmd.last;
			fv_q   <= cmd.fmt_valid;
		end
	end

	assign status.first     = first_byte;
	assign status.fld_done  = fld_done;
	assign status.tag_riff  = asm_new == TAG_RIFF;
	assign status.tag_wave  = asm_new == TAG_WAVE;
	assign status.tag_fmt   = asm_new == TAG_FMT;
	assign status.tag_skip  = (asm_new == TAG_LIST) || (asm_new == TAG_CUE)
		|| (asm_new == TAG_FACT);
	assign status.tag_data  = asm_new == TAG_DATA;
	assign status.fmt_pcm   = asm_new == FMT_PCM;
	assign status.bits_ok   = (asm_new != 32'd0) && (asm_new <= MAX_BITS);
	assign status.val_zero  = asm_new == 32'd0;
	assign status.chan_zero = chan_q == 16'd0;
	assign status.bits_zero = bits_q == 5'd0;
	assign status.rem_zero  = rem_q == 32'd0;
	assign status.rem_one   = rem_q == 32'd1;
	assign status.div_done  = div_done;
	assign status.out_busy  = valid_q && !result.ready;

	assign result.valid         = valid_q;
	assign result.event_res     = ev_q;
	assign result.payload       = pay_q;
	assign result.last_payload  = last_q;
	assign result.format_valid  = fv_q;
	assign result.channel_count = chan_q;
	assign result.rate_hz       = rate_q;
	assign result.sample_bits   = bits_q;
	assign result.sample_count  = samples_q;
	assign result.error_code    = err_q;

endmodule

// ===== rtl/whp_ctrl.sv =====
// parse phase state machine driving the datapath commands
// depends on whp_pkg
module whp_ctrl import whp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  whp_status_t status,
	output whp_cmd_t    cmd
);

	phase_t phase_q;
	phase_t phase_d;
	phase_t phase_eff;
	logic   acc;

	assign in_ready  = (phase_q != PH_DIV) && !status.out_busy;
	assign acc       = in_valid && in_ready;
	assign phase_eff = status.first ? PH_RIFF : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		if (phase_q == PH_DIV) begin
			if (status.div_done) begin
				phase_d = status.rem_zero ? PH_DONE : PH_PAYLOAD;
			end
		end else if (acc) begin
			phase_d = phase_eff;
			unique case (phase_eff)
				PH_RIFF: begin
					if (status.fld_done) phase_d = status.tag_riff ? PH_RSIZE : PH_ERROR;
				end
				PH_RSIZE: begin
					if (status.fld_done) phase_d = PH_WAVE;
				end
				PH_WAVE: begin
					if (status.fld_done) phase_d = status.tag_wave ? PH_TAG : PH_ERROR;
				end
				PH_TAG: begin
					if (status.fld_done) begin
						priority if (status.tag_fmt) phase_d = PH_FSIZE;
						else if (status.tag_skip) phase_d = PH_CSIZE;
						else if (status.tag_data && !status.chan_zero) phase_d = PH_DSIZE;
						else phase_d = PH_ERROR;
					end
				end
				PH_FSIZE: begin
					if (status.fld_done) phase_d = PH_FCAT;
				end
				PH_FCAT: begin
					if (status.fld_done) phase_d = status.fmt_pcm ? PH_FCHAN : PH_ERROR;
				end
				PH_FCHAN: begin
					if (status.fld_done) phase_d = PH_FRATE;
				end
				PH_FRATE: begin
					if (status.fld_done) phase_d = PH_FBRATE;
				end
				PH_FBRATE: begin
					if (status.fld_done) phase_d = PH_FALIGN;
				end
				PH_FALIGN: begin
					if (status.fld_done) phase_d = PH_FBITS;
				end
				PH_FBITS: begin
					if (status.fld_done) begin
						priority if (!status.bits_ok) phase_d = PH_ERROR;
						else if (status.rem_zero) phase_d = PH_TAG;
						else phase_d = PH_FSKIP;
					end
				end
				PH_FSKIP, PH_CSKIP: begin
					if (status.rem_one) phase_d = PH_TAG;
				end
				PH_CSIZE: begin
					if (status.fld_done) phase_d = status.val_zero ? PH_TAG : PH_CSKIP;
				end
				PH_DSIZE: begin
					if (status.fld_done) begin
						phase_d = (status.chan_zero || status.bits_zero) ? PH_ERROR : PH_DIV;
					end
				end
				PH_PAYLOAD: begin
					if (status.rem_one) phase_d = PH_DONE;
				end
				PH_DONE: ;
				default: phase_d = PH_ERROR;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.rem_op    = REM_HOLD;
		cmd.err       = ERR_NONE;
		cmd.ev        = EV_HDR;
		cmd.fmt_valid = (phase_d == PH_PAYLOAD) || (phase_d == PH_DONE);
		if (phase_q == PH_DIV) begin
			if (status.div_done) begin
				cmd.out_load    = 1'b1;
				cmd.set_samples = 1'b1;
			end
		end else if (acc) begin
			cmd.restart  = status.first;
			cmd.out_load = 1'b1;
			unique case (phase_eff)
				PH_RIFF: begin
					cmd.collect = 1'b1;
					cmd.big     = 1'b1;
					if (status.fld_done && !status.tag_riff) begin
						cmd.set_err = 1'b1;
						cmd.err     = ERR_RIFF;
						cmd.ev      = EV_ERR;
					end
				end
				PH_RSIZE, PH_FBRATE: begin
					cmd.collect = 1'b1;
				end
				PH_WAVE: begin
					cmd.collect = 1'b1;
					cmd.big     = 1'b1;
					if (status.fld_done && !status.tag_wave) begin
						cmd.set_err = 1'b1;
						cmd.err     = ERR_WAVE;
						cmd.ev      = EV_ERR;
					end
				end
				PH_TAG: begin
					cmd.collect = 1'b1;
					cmd.big     = 1'b1;
					if (status.fld_done && !status.tag_fmt && !status.tag_skip) begin
						cmd.set_err = 1'b1;
						cmd.ev      = EV_ERR;
						cmd.err     = status.tag_data ? ERR_NOFMT : ERR_CHUNK;
						if (status.tag_data && !status.chan_zero) begin
							cmd.set_err = 1'b0;
							cmd.err     = ERR_NONE;
							cmd.ev      = EV_HDR;
						end
					end
				end
				PH_FSIZE: begin
					cmd.collect = 1'b1;
					if (status.fld_done) cmd.rem_op = REM_FMT;
				end
				PH_FCAT: begin
					cmd.collect  = 1'b1;
					cmd.two_byte = 1'b1;
					if (status.fld_done && !status.fmt_pcm) begin
						cmd.set_err = 1'b1;
						cmd.err     = ERR_PCM;
						cmd.ev      = EV_ERR;
					end
				end
				PH_FCHAN: begin
					cmd.collect  = 1'b1;
					cmd.two_byte = 1'b1;
					cmd.set_chan = status.fld_done;
				end
				PH_FRATE: begin
					cmd.collect  = 1'b1;
					cmd.set_rate = status.fld_done;
				end
				PH_FALIGN: begin
					cmd.collect  = 1'b1;
					cmd.two_byte = 1'b1;
				end
				PH_FBITS: begin
					cmd.collect  = 1'b1;
					cmd.two_byte = 1'b1;
					if (status.fld_done) begin
						if (status.bits_ok) begin
							cmd.set_bits = 1'b1;
						end else begin
							cmd.set_err = 1'b1;
							cmd.err     = ERR_BITS;
							cmd.ev      = EV_ERR;
						end
					end
				end
				PH_FSKIP, PH_CSKIP: begin
					cmd.rem_op = REM_DEC;
				end
				PH_CSIZE: begin
					cmd.collect = 1'b1;
					if (status.fld_done) cmd.rem_op = REM_LOAD;
				end
				PH_DSIZE: begin
					cmd.collect = 1'b1;
					if (status.fld_done) begin
						if (status.chan_zero || status.bits_zero) begin
							cmd.set_err = 1'b1;
							cmd.err     = ERR_NOFMT;
							cmd.ev      = EV_ERR;
						end else begin
							// result waits for the sample count division
							cmd.rem_op    = REM_LOAD;
							cmd.div_start = 1'b1;
							cmd.out_load  = 1'b0;
						end
					end
				end
				PH_PAYLOAD: begin
					cmd.ev     = EV_PAY;
					cmd.rem_op = REM_DEC;
					cmd.last   = status.rem_one;
				end
				PH_DONE: begin
					cmd.ev = EV_IGN;
				end
				default: begin
					cmd.ev = EV_ERR;
				end
			endcase
		end
	end

endmodule

// ===== rtl/wav_header_parser_top.sv =====
// RIFF/WAVE PCM header parser: takes one file byte per transfer and returns one
// result per byte. The byte that completes the data chunk size waits for the
// bit-serial divider that forms the sample count as size / (channels * bytes
// per sample), one quotient bit per cycle; no new byte is taken while it runs.
// A result that waits at the output holds off the next byte, which can be
// taken in the cycle that result is transferred. first_byte restarts the
// parser on that byte.
// depends on whp_pkg, whp_if, whp_ctrl and whp_datapath
module wav_header_parser_top import whp_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	whp_byte_if.sink  stream,
	whp_res_if.source result
);

	whp_cmd_t    cmd;
	whp_status_t status;
	logic        rdy;

	assign stream.ready = rdy;

	whp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_ready (rdy),
		.status   (status),
		.cmd      (cmd)
	);

	whp_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (stream.in_byte),
		.first_byte (stream.first_byte),
		.cmd        (cmd),
		.status     (status),
		.result     (result)
	);

endmodule
